// ===== rtl/b64sd_pkg.sv =====
package b64sd_pkg;

    // Largest message in characters; the byte count saturates at the bytes it can decode
    localparam int unsigned MaxChars  = 4096;
    localparam int unsigned ByteCapRaw = (MaxChars / 4) * 3;
    localparam int unsigned ByteCapInt = (ByteCapRaw > 4095) ? 4095 : ByteCapRaw;

    localparam int unsigned CharW  = 8;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned TotalW = 12;
    localparam int unsigned SxW    = 6;

    localparam logic [TotalW-1:0] BYTE_CAP = TotalW'(ByteCapInt);

    // Result queue: room for the largest burst of one character plus slack
    localparam int unsigned MaxRes = 4;
    localparam int unsigned QDepth = 8;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);
    localparam int unsigned NResW  = $clog2(MaxRes + 1);

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_LEN  = 2'd2,
        KIND_BAD_CHAR = 2'd3
    } kind_t;

    typedef struct packed {
        logic [ByteW-1:0]  data_byte;
        kind_t             kind;
        logic [TotalW-1:0] byte_total;
        logic              run_end;
    } result_t;

    typedef struct packed {
        logic           valid;
        logic [SxW-1:0] value;
    } sextet_t;

    // Standard alphabet lookup; anything else, '=' and codes of 128 up, is invalid
    function automatic sextet_t sextet_of(input logic [CharW-1:0] c);
        sextet_t s;
        s.valid = 1'b1;
        s.value = '0;
        if (c inside {[8'h41:8'h5A]}) begin
            s.value = SxW'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.value = SxW'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.value = SxW'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = SxW'(62);
        end else if (c == 8'h2F) begin
            s.value = SxW'(63);
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] n);
        return (n < BYTE_CAP) ? n + 1'b1 : n;
    endfunction

endpackage

// ===== rtl/base64_stream_decoder_unit.sv =====
// Channel | Ports                         | Word contents (lowest bit up)
// input   | s_tvalid s_tready s_tdata s_tlast | tdata: in_char[7:0]; tlast: last_char
// output  | m_tvalid m_tready m_tdata m_tuser m_tlast
//         |                               | tdata: data_byte[7:0], byte_total[19:8], zero
//         |                               | tuser: kind; tlast: run_end
//
// One character is taken per cycle; its zero to four result words are decoded in
// that same cycle and written into an eight-entry result queue, which drains one
// word per cycle. The input stalls only while the queue has fewer than four free
// entries. Reset is synchronous, active low, clears decode state and empties the
// queue. A stalled output holds its word; input keeps flowing while four entries are free.
module base64_stream_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte[7:0], byte_total[19:8], zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // run_end
);
    import b64sd_pkg::*;

    logic [1:0]        phase_reg,   phase_next;
    logic [3*SxW-1:0]  held_reg,    held_next;
    logic              third_void_reg, third_void_next;
    logic              stopped_reg, stopped_next;
    logic              bad_reg,     bad_next;
    logic [TotalW-1:0] bytes_reg,   bytes_next;

    result_t           q_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]  count_reg,  count_next;

    logic              s_fire, m_fire;
    sextet_t           sx;
    logic [SxW-1:0]    v0, v1, v2;
    logic [ByteW-1:0]  b0, b1, b2;
    logic [TotalW-1:0] t1, t2, t3;
    result_t           res [MaxRes];
    logic [NResW-1:0]  nres;
    logic [NResW-1:0]  ndata;
    logic [1:0]        phase_inc;
    kind_t             end_kind;
    result_t           head;

    assign s_tready = (count_reg <= QCntW'(QDepth - MaxRes));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;

    assign sx = sextet_of(s_tdata);
    assign v0 = held_reg[3*SxW-1:2*SxW];
    assign v1 = held_reg[2*SxW-1:SxW];
    assign v2 = held_reg[SxW-1:0];
    assign b0 = {v0, v1[5:4]};
    assign b1 = {v1[3:0], v2[5:2]};
    assign b2 = {v2[1:0], sx.value};
    assign t1 = sat_inc(bytes_reg);
    assign t2 = sat_inc(t1);
    assign t3 = sat_inc(t2);
    assign phase_inc = phase_reg + 2'd1;

    always_comb begin
        phase_next      = phase_reg;
        held_next       = held_reg;
        third_void_next = third_void_reg;
        stopped_next    = stopped_reg;
        bad_next        = bad_reg;
        bytes_next      = bytes_reg;
        ndata           = '0;
        end_kind        = KIND_GOOD;
        for (int i = 0; i < MaxRes; i++) begin
            res[i] = '{data_byte: '0, kind: KIND_DATA, byte_total: '0, run_end: 1'b0};
        end
        res[0].data_byte = b0;
        res[0].byte_total = t1;
        res[1].data_byte = b1;
        res[1].byte_total = t2;
        res[2].data_byte = b2;
        res[2].byte_total = t3;

        if (s_fire) begin
            if (!stopped_reg && !bad_reg) begin
                case (phase_reg)
                    2'd0: begin
                        if (!sx.valid) bad_next = 1'b1;
                        else held_next = {sx.value, {(2*SxW){1'b0}}};
                    end
                    2'd1: begin
                        if (!sx.valid) bad_next = 1'b1;
                        else held_next = {v0, sx.value, {SxW{1'b0}}};
                    end
                    2'd2: begin
                        third_void_next = !sx.valid;
                        held_next = {v0, v1, (sx.valid ? sx.value : {SxW{1'b0}})};
                    end
                    default: begin
                        // Padding in third or fourth place ends decoding for the message
                        if (third_void_reg) begin
                            ndata = NResW'(1);
                            bytes_next = t1;
                            stopped_next = 1'b1;
                        end else if (!sx.valid) begin
                            ndata = NResW'(2);
                            bytes_next = t2;
                            stopped_next = 1'b1;
                        end else begin
                            ndata = NResW'(3);
                            bytes_next = t3;
                        end
                        third_void_next = 1'b0;
                    end
                endcase
            end
            phase_next = phase_inc;

            if (phase_inc != 2'd0) end_kind = KIND_BAD_LEN;
            else if (bad_next) end_kind = KIND_BAD_CHAR;
            else end_kind = KIND_GOOD;

            if (s_tlast) begin
                // End word sits right after the data words
                res[ndata[1:0]] = '{data_byte: '0, kind: end_kind,
                                    byte_total: bytes_next, run_end: 1'b1};
                phase_next      = '0;
                held_next       = '0;
                third_void_next = 1'b0;
                stopped_next    = 1'b0;
                bad_next        = 1'b0;
                bytes_next      = '0;
            end else if (ndata != '0) begin
                res[ndata[1:0] - 2'd1].run_end = 1'b1;
            end
        end

        nres = (s_fire && s_tlast) ? ndata + NResW'(1) : ndata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= '0;
            held_reg       <= '0;
            third_void_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            bad_reg        <= 1'b0;
            bytes_reg      <= '0;
        end else begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            third_void_reg <= third_void_next;
            stopped_reg    <= stopped_next;
            bad_reg        <= bad_next;
            bytes_reg      <= bytes_next;
        end
    end

    // Result queue
    assign wr_ptr_next = wr_ptr_reg + QPtrW'(nres);
    assign rd_ptr_next = m_fire ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
    assign count_next  = count_reg + QCntW'(nres) - QCntW'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxRes; i++) begin
            if (NResW'(i) < nres) begin
                q_reg[wr_ptr_reg + QPtrW'(i)] <= res[i];
            end
        end
    end

    assign head    = q_reg[rd_ptr_reg];
    assign m_tdata = {4'b0000, head.byte_total, head.data_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_end;

endmodule

// ===== tb/sv/b64_decode_checker.sv =====
`timescale 1ns / 1ps

module b64_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_char
    input  logic        s_tlast,   // last_char
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // data_byte[7:0], byte_total[19:8], zero pad
    input  logic [1:0]  m_tuser,   // kind
    input  logic        m_tlast,   // run_end
    output int          mismatches,
    output int          words_due,
    output int          words_seen,
    output int          ends_seen
);
    import b64sd_pkg::*;

    localparam logic [6:0] NO_SEXTET = 7'd64;

    // decoder image
    logic [1:0]  grp_pos;
    logic [17:0] held;
    logic        third_pad;
    logic        halted;
    logic        bad_seen;
    logic [11:0] out_count;

    result_t decoded_words_due[$];
    result_t burst[MaxRes];
    int      burst_n;
    int      errors;
    int      seen_n;
    int      ends_n;

    assign mismatches = errors;
    assign words_seen = seen_n;
    assign ends_seen  = ends_n;

    initial begin
        errors    = 0;
        seen_n    = 0;
        ends_n    = 0;
        words_due = 0;
    end

    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
        if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
        if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
        if (c == 8'h2B) return 7'd62;
        if (c == 8'h2F) return 7'd63;
        return NO_SEXTET;
    endfunction

    task automatic clear_decoder();
        grp_pos   = '0;
        held      = '0;
        third_pad = 1'b0;
        halted    = 1'b0;
        bad_seen  = 1'b0;
        out_count = '0;
    endtask

    task automatic add_word(input logic [7:0] b, input kind_t k);
        if (k == KIND_DATA && out_count < BYTE_CAP) out_count = out_count + 1'b1;
        burst[burst_n].data_byte  = b;
        burst[burst_n].kind       = k;
        burst[burst_n].byte_total = out_count;
        burst[burst_n].run_end    = 1'b0;
        burst_n++;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0] sx;
        logic       ok;
        logic [5:0] v0, v1, v2;
        kind_t      k;
        sx = char_sextet(c);
        ok = !sx[6];
        burst_n = 0;
        if (!halted && !bad_seen) begin
            v0 = held[17:12];
            v1 = held[11:6];
            v2 = held[5:0];
            case (grp_pos)
                2'd0: begin
                    if (!ok) bad_seen = 1'b1;
                    else held = {sx[5:0], 12'd0};
                end
                2'd1: begin
                    if (!ok) bad_seen = 1'b1;
                    else held = {held[17:12], sx[5:0], 6'd0};
                end
                2'd2: begin
                    third_pad = !ok;
                    held = {held[17:6], ok ? sx[5:0] : 6'd0};
                end
                default: begin
                    add_word({v0, v1[5:4]}, KIND_DATA);
                    if (third_pad) begin
                        halted = 1'b1;
                    end else begin
                        add_word({v1[3:0], v2[5:2]}, KIND_DATA);
                        if (!ok) halted = 1'b1;
                        else add_word({v2[1:0], sx[5:0]}, KIND_DATA);
                    end
                    third_pad = 1'b0;
                end
            endcase
        end
        grp_pos = grp_pos + 1'b1;
        if (last) begin
            if (grp_pos != 2'd0) k = KIND_BAD_LEN;
            else if (bad_seen) k = KIND_BAD_CHAR;
            else k = KIND_GOOD;
            add_word(8'd0, k);
            clear_decoder();
        end
        for (int i = 0; i < burst_n; i++) begin
            burst[i].run_end = (i == burst_n - 1);
            decoded_words_due.push_back(burst[i]);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        result_t due;
        if (!aresetn) begin
            clear_decoder();
            decoded_words_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen_n++;
                if (m_tuser != KIND_DATA) ends_n++;
                if (decoded_words_due.size() == 0) begin
                    $error("result word with nothing due: tdata %h tuser %0d tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    due = decoded_words_due.pop_front();
                    check_field("data_byte", due.data_byte, m_tdata[7:0]);
                    check_field("byte_total", due.byte_total, m_tdata[19:8]);
                    check_field("tdata pad", 0, m_tdata[23:20]);
                    check_field("kind", due.kind, m_tuser);
                    check_field("run_end", due.run_end, m_tlast);
                end
            end
            if (s_tvalid && s_tready) decode_char(s_tdata, s_tlast);
        end
        words_due <= decoded_words_due.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import b64sd_pkg::*;

    localparam int         RAND_ITEMS  = 420;
    localparam int         HOLD_CYCLES = 400;
    localparam int         TAIL_CYCLES = 20;
    localparam int         CYCLE_LIMIT = 500000;
    localparam logic [7:0] PAD_CHAR    = 8'h3D;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // in_char
    logic        s_tlast  = 1'b0;   // last_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // data_byte[7:0], byte_total[19:8], zero pad
    logic [1:0]  m_tuser;           // kind
    logic        m_tlast;           // run_end

    int mismatches, words_due, words_seen, ends_seen;
    int cycle_count = 0;
    int chars_sent  = 0;
    int msgs_sent   = 0;
    int rand_chars  = 0;
    bit no_gaps     = 1'b0;
    bit hold_ask    = 1'b0;

    logic [7:0] msg[$];

    base64_stream_decoder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    b64_decode_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .words_due  (words_due),
        .words_seen (words_seen),
        .ends_seen  (ends_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int   stall;
        logic got;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_ask) begin
                stall = HOLD_CYCLES;
                hold_ask = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 3);
            end
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(negedge aclk);
                got = m_tvalid;
                @(posedge aclk);
            end
        end
    end

    function automatic logic [7:0] alpha_of(input int unsigned i);
        if (i < 26) return 8'(8'h41 + i);
        if (i < 52) return 8'(8'h61 + i - 26);
        if (i < 62) return 8'(8'h30 + i - 52);
        if (i == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic logic [7:0] invalid_char();
        case ($urandom_range(0, 3))
            0:       return PAD_CHAR;
            1:       return 8'($urandom_range(128, 255));
            2:       return 8'($urandom_range(0, 42));
            default: return 8'($urandom_range(123, 127));
        endcase
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endtask

    // append whole groups; pad the tail of the last group
    task automatic add_groups(input int groups, input int pad);
        for (int g = 0; g < groups; g++) begin
            for (int j = 0; j < 4; j++) begin
                if (g == groups - 1 && j >= 4 - pad)
                    msg.push_back($urandom_range(0, 3) == 0 ? invalid_char() : PAD_CHAR);
                else
                    msg.push_back(alpha_of($urandom_range(0, 63)));
            end
        end
    endtask

    task automatic send_word(input logic [7:0] c, input logic last);
        int   gap;
        logic took;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end
        chars_sent++;
    endtask

    task automatic send_msg();
        for (int i = 0; i < msg.size(); i++) send_word(msg[i], i == msg.size() - 1);
        msgs_sent++;
        msg.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
    endtask

    initial begin
        int pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: full group, one and two pad chars, alphabet edges, bad chars
        push_str("TWFu");
        send_msg();
        push_str("TQ==");
        send_msg();
        push_str("TWE=");
        send_msg();
        push_str("+/9zAZa0");
        send_msg();
        msg.push_back(8'hFF);
        push_str("AAA");
        send_msg();
        // bad length wins over bad char
        push_str("A");
        msg.push_back(8'h80);
        send_msg();
        wait_drained();

        // fill the result queue behind a long output stall, then drain
        hold_ask = 1'b1;
        add_groups(12, 0);
        send_msg();
        wait_drained();

        while (rand_chars < RAND_ITEMS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 3);
                add_groups($urandom_range(1, 5), pick == 3 ? 0 : pick);
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: begin
                        add_groups($urandom_range(1, 4), 0);
                        msg[$urandom_range(0, msg.size() - 1)] = invalid_char();
                    end
                    1: begin
                        add_groups($urandom_range(1, 4), 0);
                        msg.push_back(alpha_of($urandom_range(0, 63)));
                    end
                    2: begin
                        // groups after padding are never decoded
                        add_groups($urandom_range(1, 2), $urandom_range(1, 2));
                        add_groups($urandom_range(1, 2), 0);
                    end
                    default: begin
                        add_groups($urandom_range(1, 4), 0);
                        void'(msg.pop_back());
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
            end
            rand_chars += msg.size();
            send_msg();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d characters in %0d messages; %0d result words checked, %0d end words",
                 chars_sent, msgs_sent, words_seen, ends_seen);
        $display("covered padding, bad length and char, stop after pad, long stall");
        if (mismatches == 0 && words_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
